>>> rtl/assert_macros.svh
// assertion macros shared by the timer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// plain property, checked on every clock edge outside reset
`define HMS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("timer assertion failed");
// same-cycle implication
`define HMS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer implication failed");
`else
`define HMS_ASSERT(label, clk, rst, prop)
`define HMS_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/hmstmr_pkg.sv
// types and constants shared by the timer modules
`timescale 1ns / 1ps
`default_nettype none
package hmstmr_pkg;

   typedef enum logic [2:0] {
      ACT_TICK,
      ACT_START,
      ACT_PAUSE,
      ACT_STOP,
      ACT_RESTART,
      ACT_LOAD
   } action_type;

   typedef enum logic [1:0] {
      MODE_DOWN,
      MODE_UP,
      MODE_EVENTS
   } mode_type;

   typedef enum logic [2:0] {
      CSR_PRESET_HOURS,
      CSR_PRESET_MINUTES,
      CSR_PRESET_SECONDS,
      CSR_COUNT_MODE,
      CSR_TICK_INTERVAL,
      CSR_CALIBRATION
   } csr_index_type;

   localparam int unsigned ACTION_W    = 3;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned CARRY_W     = 16;

   localparam int unsigned MINSEC_LIMIT = 59;

   // load total fits 34 bits for any hour limit up to 1193
   localparam int unsigned LOAD_W = 34;
   localparam logic [LOAD_W-1:0] MS_PER_HOUR = 34'd3600000;
   localparam logic [LOAD_W-1:0] MS_PER_MIN  = 34'd60000;
   localparam logic [LOAD_W-1:0] MS_PER_SEC  = 34'd1000;

   localparam logic [COUNT_W-1:0] COUNT_MAX           = '1;
   localparam logic [COUNT_W-1:0] TICK_INTERVAL_RESET = 32'd1000;
   localparam logic [COUNT_W-1:0] CAL_ONE             = 32'h0001_0000;

   // split of a millisecond count into h/m/s
   localparam int unsigned SEC_W       = 23;
   localparam int unsigned HOURS_W     = 11;
   localparam int unsigned TOTMIN_W    = 17;
   localparam int unsigned CLOCK_W     = 6;
   localparam int unsigned HOURS_OUT_W = 16;
   localparam int unsigned SEC_PER_MIN = 60;

   // reciprocals, exact over the full input range
   localparam logic [28:0] RECIP_MS        = 29'd274877907;
   localparam int unsigned RECIP_MS_SHIFT  = 38;
   localparam logic [22:0] RECIP_HOUR      = 23'd4772186;
   localparam int unsigned RECIP_HOUR_SHIFT = 34;
   localparam logic [23:0] RECIP_MIN       = 24'd8947849;
   localparam int unsigned RECIP_MIN_SHIFT = 29;

   typedef struct packed {
      logic fired;
      logic done;
      logic running;
      logic stopped;
      logic completed;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/hmstmr_engine.sv
// timer state, configuration registers and per-item state update
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hmstmr_engine import hmstmr_pkg::*; #(
   parameter int unsigned HOUR_LIMIT = 999
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   step,
   input  logic [ACTION_W-1:0]    action,
   input  logic [COUNT_W-1:0]     now_ms,
   output status_type             status,
   output logic [COUNT_W-1:0]     count
);

   localparam int unsigned HourW = $clog2(HOUR_LIMIT + 1);

   logic [15:0]          preset_hours_ff;
   logic [7:0]           preset_minutes_ff;
   logic [7:0]           preset_seconds_ff;
   logic [1:0]           count_mode_ff;
   logic [COUNT_W-1:0]   tick_interval_ff;
   logic [COUNT_W-1:0]   calibration_ff;

   logic [COUNT_W-1:0]   count_now_ff, count_now_in;
   logic [COUNT_W-1:0]   count_full_ff, count_full_in;
   logic [COUNT_W-1:0]   count_origin_ff, count_origin_in;
   logic [COUNT_W-1:0]   last_ref_ff, last_ref_in;
   logic                 stopped_ff, stopped_in;
   logic                 completed_ff, completed_in;
   logic [CARRY_W-1:0]   carry_ff, carry_in;

   logic [HourW-1:0]     hours_clamp;
   logic [5:0]           minutes_clamp;
   logic [5:0]           seconds_clamp;
   logic [LOAD_W-1:0]    load_total;
   logic [COUNT_W-1:0]   load_count;

   logic [COUNT_W-1:0]   elapsed;
   logic                 interval_due;
   logic [COUNT_W-1:0]   factor;
   logic [2*COUNT_W-1:0] corrected;
   logic                 whole_over;
   logic [COUNT_W-1:0]   delta;
   logic [CARRY_W-1:0]   carry_tick;
   logic [COUNT_W:0]     up_sum;
   logic                 down_left;
   logic                 up_left;
   logic [COUNT_W-1:0]   stop_count;
   logic                 fired;
   logic                 done;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         preset_hours_ff   <= '0;
         preset_minutes_ff <= '0;
         preset_seconds_ff <= '0;
         count_mode_ff     <= MODE_DOWN;
         tick_interval_ff  <= TICK_INTERVAL_RESET;
         calibration_ff    <= CAL_ONE;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PRESET_HOURS:   preset_hours_ff   <= csr_write_data[15:0];
            CSR_PRESET_MINUTES: preset_minutes_ff <= csr_write_data[7:0];
            CSR_PRESET_SECONDS: preset_seconds_ff <= csr_write_data[7:0];
            CSR_COUNT_MODE:     count_mode_ff     <= csr_write_data[1:0];
            CSR_TICK_INTERVAL:  tick_interval_ff  <= csr_write_data;
            CSR_CALIBRATION:    calibration_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // preset to milliseconds, saturating
   assign hours_clamp   = (preset_hours_ff > 16'(HOUR_LIMIT)) ? HourW'(HOUR_LIMIT)
                                                              : preset_hours_ff[HourW-1:0];
   assign minutes_clamp = (preset_minutes_ff > 8'(MINSEC_LIMIT)) ? 6'(MINSEC_LIMIT)
                                                                 : preset_minutes_ff[5:0];
   assign seconds_clamp = (preset_seconds_ff > 8'(MINSEC_LIMIT)) ? 6'(MINSEC_LIMIT)
                                                                 : preset_seconds_ff[5:0];
   assign load_total = LOAD_W'(hours_clamp) * MS_PER_HOUR
                     + LOAD_W'(minutes_clamp) * MS_PER_MIN
                     + LOAD_W'(seconds_clamp) * MS_PER_SEC;
   assign load_count = (|load_total[LOAD_W-1:COUNT_W]) ? COUNT_MAX : load_total[COUNT_W-1:0];

   // scaled elapsed time, q16.16 with carried fraction
   assign elapsed      = now_ms - last_ref_ff;
   assign interval_due = (elapsed >= tick_interval_ff);
   assign factor       = (calibration_ff == '0) ? CAL_ONE : calibration_ff;
   assign corrected    = (2*COUNT_W)'(elapsed) * (2*COUNT_W)'(factor)
                       + (2*COUNT_W)'(carry_ff);
   assign whole_over   = |corrected[2*COUNT_W-1:COUNT_W+CARRY_W];
   assign delta        = whole_over ? COUNT_MAX : corrected[COUNT_W+CARRY_W-1:CARRY_W];
   assign carry_tick   = whole_over ? '0 : corrected[CARRY_W-1:0];

   assign down_left  = (count_now_ff > delta);
   assign up_sum     = {1'b0, count_now_ff} + {1'b0, delta};
   assign up_left    = (up_sum < {1'b0, count_full_ff});
   assign stop_count = (count_mode_ff == MODE_UP) ? '0 : count_full_ff;

   always_comb begin
      count_now_in    = count_now_ff;
      count_full_in   = count_full_ff;
      count_origin_in = count_origin_ff;
      last_ref_in     = last_ref_ff;
      stopped_in      = stopped_ff;
      completed_in    = completed_ff;
      carry_in        = carry_ff;
      fired           = 1'b0;
      done            = 1'b0;
      unique case (action_type'(action))
         ACT_TICK: begin
            if (!completed_ff && !stopped_ff && interval_due) begin
               last_ref_in = now_ms;
               carry_in    = carry_tick;
               priority if (count_mode_ff == MODE_DOWN) begin
                  if (down_left) begin
                     count_now_in = count_now_ff - delta;
                     fired        = 1'b1;
                  end else begin
                     stopped_in   = 1'b1;
                     completed_in = 1'b1;
                     count_now_in = stop_count;
                     done         = 1'b1;
                  end
               end else if (count_mode_ff == MODE_UP) begin
                  if (up_left) begin
                     count_now_in = up_sum[COUNT_W-1:0];
                     fired        = 1'b1;
                  end else begin
                     stopped_in   = 1'b1;
                     completed_in = 1'b1;
                     count_now_in = stop_count;
                     done         = 1'b1;
                  end
               end else begin
                  // interval events only, the spare mode included
                  fired = 1'b1;
               end
            end
         end
         ACT_START: begin
            if (stopped_ff) begin
               stopped_in  = 1'b0;
               last_ref_in = now_ms;
               carry_in    = '0;
            end
            completed_in = 1'b0;
         end
         ACT_PAUSE: begin
            stopped_in = 1'b1;
         end
         ACT_STOP: begin
            stopped_in   = 1'b1;
            completed_in = 1'b1;
            count_now_in = stop_count;
         end
         ACT_RESTART: begin
            count_now_in = count_origin_ff;
            completed_in = 1'b0;
            stopped_in   = 1'b0;
            last_ref_in  = now_ms;
            carry_in     = '0;
         end
         ACT_LOAD: begin
            count_full_in   = load_count;
            count_now_in    = (count_mode_ff == MODE_UP) ? '0 : load_count;
            count_origin_in = (count_mode_ff == MODE_UP) ? '0 : load_count;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_now_ff    <= '0;
         count_full_ff   <= '0;
         count_origin_ff <= '0;
         last_ref_ff     <= '0;
         stopped_ff      <= 1'b1;
         completed_ff    <= 1'b0;
         carry_ff        <= '0;
      end else if (step) begin
         count_now_ff    <= count_now_in;
         count_full_ff   <= count_full_in;
         count_origin_ff <= count_origin_in;
         last_ref_ff     <= last_ref_in;
         stopped_ff      <= stopped_in;
         completed_ff    <= completed_in;
         carry_ff        <= carry_in;
      end
   end

   assign status.fired     = fired;
   assign status.done      = done;
   assign status.running   = !stopped_in && !completed_in;
   assign status.stopped   = stopped_in;
   assign status.completed = completed_in;
   assign count            = count_now_in;

   `HMS_ASSERT(a_completed_is_stopped, clock, reset, completed_ff |-> stopped_ff)
   `HMS_ASSERT(a_count_within_full, clock, reset, count_now_ff <= count_full_ff)
   `HMS_ASSERT(a_done_sets_flags, clock, reset, (step && done) |=> (completed_ff && stopped_ff))

endmodule
`default_nettype wire

>>> rtl/hmstmr_split.sv
// result pipeline: splits the millisecond count into hours, minutes and seconds
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hmstmr_split import hmstmr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  status_type             in_status,
   input  logic [COUNT_W-1:0]     in_count,
   output logic                   out_valid,
   input  logic                   out_ready,
   output status_type             out_status,
   output logic [COUNT_W-1:0]     out_count,
   output logic [HOURS_OUT_W-1:0] out_hours,
   output logic [CLOCK_W-1:0]     out_minutes,
   output logic [CLOCK_W-1:0]     out_seconds
);

   localparam int unsigned MsProdW   = COUNT_W + $bits(RECIP_MS);
   localparam int unsigned HourProdW = SEC_W + $bits(RECIP_HOUR);
   localparam int unsigned MinProdW  = SEC_W + $bits(RECIP_MIN);

   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic a_ready, b_ready, c_ready, d_ready;

   status_type           a_status_ff, b_status_ff, c_status_ff, d_status_ff;
   logic [COUNT_W-1:0]   a_count_ff, b_count_ff, c_count_ff, d_count_ff;
   logic [SEC_W-1:0]     b_secs_ff, b_secs_in;
   logic [SEC_W-1:0]     c_secs_ff;
   logic [HOURS_W-1:0]   c_hours_ff, c_hours_in;
   logic [TOTMIN_W-1:0]  c_totmin_ff, c_totmin_in;
   logic [HOURS_OUT_W-1:0] d_hours_ff;
   logic [CLOCK_W-1:0]   d_minutes_ff, d_minutes_in;
   logic [CLOCK_W-1:0]   d_seconds_ff, d_seconds_in;

   logic [MsProdW-1:0]   ms_prod;
   logic [HourProdW-1:0] hour_prod;
   logic [MinProdW-1:0]  min_prod;
   logic [TOTMIN_W-1:0]  minutes_wide;
   logic [SEC_W-1:0]     seconds_wide;

   // each stage fills whenever the one after it can move
   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign ms_prod   = MsProdW'(a_count_ff) * MsProdW'(RECIP_MS);
   assign b_secs_in = ms_prod[RECIP_MS_SHIFT +: SEC_W];

   assign hour_prod   = HourProdW'(b_secs_ff) * HourProdW'(RECIP_HOUR);
   assign min_prod    = MinProdW'(b_secs_ff) * MinProdW'(RECIP_MIN);
   assign c_hours_in  = hour_prod[RECIP_HOUR_SHIFT +: HOURS_W];
   assign c_totmin_in = min_prod[RECIP_MIN_SHIFT +: TOTMIN_W];

   // remainders by constant multiply and subtract, both below sixty
   assign minutes_wide = c_totmin_ff - TOTMIN_W'(c_hours_ff) * TOTMIN_W'(SEC_PER_MIN);
   assign seconds_wide = c_secs_ff - SEC_W'(c_totmin_ff) * SEC_W'(SEC_PER_MIN);
   assign d_minutes_in = minutes_wide[CLOCK_W-1:0];
   assign d_seconds_in = seconds_wide[CLOCK_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
         if (d_ready) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_status_ff <= in_status;
         a_count_ff  <= in_count;
      end
      if (b_ready) begin
         b_status_ff <= a_status_ff;
         b_count_ff  <= a_count_ff;
         b_secs_ff   <= b_secs_in;
      end
      if (c_ready) begin
         c_status_ff <= b_status_ff;
         c_count_ff  <= b_count_ff;
         c_secs_ff   <= b_secs_ff;
         c_hours_ff  <= c_hours_in;
         c_totmin_ff <= c_totmin_in;
      end
      if (d_ready) begin
         d_status_ff  <= c_status_ff;
         d_count_ff   <= c_count_ff;
         d_hours_ff   <= HOURS_OUT_W'(c_hours_ff);
         d_minutes_ff <= d_minutes_in;
         d_seconds_ff <= d_seconds_in;
      end
   end

   assign out_valid   = d_valid_ff;
   assign out_status  = d_status_ff;
   assign out_count   = d_count_ff;
   assign out_hours   = d_hours_ff;
   assign out_minutes = d_minutes_ff;
   assign out_seconds = d_seconds_ff;

   `HMS_ASSERT_IMPL(a_minutes_range, clock, reset, out_valid, out_minutes < 6'd60)
   `HMS_ASSERT_IMPL(a_seconds_range, clock, reset, out_valid, out_seconds < 6'd60)
   `HMS_ASSERT_IMPL(a_hours_range, clock, reset, out_valid, out_hours <= 16'd1193)

endmodule
`default_nettype wire

>>> rtl/calibrated_hms_countdown_timer.sv
// top level of the calibrated hours/minutes/seconds countdown and count-up timer
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  action, now_ms
//   rsp_      out        rsp_valid / rsp_ready  events, flags, count in ms and h/m/s
//   csr_      in         csr_write_enable       csr_index, csr_write_data
//
// one item per cycle while req_ready is high; results pass split stages a to d
// the timer state updates straight from the input register: the 32x32 scale
// multiply with its add and compare sets the clock period
// synchronous reset clears the stage valids and the timer state; no clearing pass
// each stage fills while the next one waits, so req_ready drops only when all five
// stages hold items and rsp_ready is low
`timescale 1ns / 1ps
`default_nettype none
module calibrated_hms_countdown_timer import hmstmr_pkg::*; #(
   parameter int unsigned HOUR_LIMIT = 999
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [COUNT_W-1:0]     req_now_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_interval_fired,
   output logic                   rsp_completed_event,
   output logic                   rsp_is_running,
   output logic                   rsp_is_stopped,
   output logic                   rsp_is_completed,
   output logic [COUNT_W-1:0]     rsp_current_ms,
   output logic [HOURS_OUT_W-1:0] rsp_current_hours,
   output logic [CLOCK_W-1:0]     rsp_current_minutes,
   output logic [CLOCK_W-1:0]     rsp_current_seconds,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic                in_valid_ff;
   logic [ACTION_W-1:0] in_action_ff;
   logic [COUNT_W-1:0]  in_now_ff;
   logic                in_ready;
   logic                split_ready;
   logic                step;
   status_type          step_status;
   logic [COUNT_W-1:0]  step_count;
   status_type          rsp_status;

   assign in_ready  = !in_valid_ff || split_ready;
   assign req_ready = in_ready;
   // the timer state advances as the item moves into the result pipeline
   assign step      = in_valid_ff && split_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_action_ff <= req_action;
         in_now_ff    <= req_now_ms;
      end
   end

   hmstmr_engine #(
      .HOUR_LIMIT (HOUR_LIMIT)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .step             (step),
      .action           (in_action_ff),
      .now_ms           (in_now_ff),
      .status           (step_status),
      .count            (step_count)
   );

   hmstmr_split u_split (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_valid_ff),
      .in_ready    (split_ready),
      .in_status   (step_status),
      .in_count    (step_count),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_status  (rsp_status),
      .out_count   (rsp_current_ms),
      .out_hours   (rsp_current_hours),
      .out_minutes (rsp_current_minutes),
      .out_seconds (rsp_current_seconds)
   );

   assign rsp_interval_fired  = rsp_status.fired;
   assign rsp_completed_event = rsp_status.done;
   assign rsp_is_running      = rsp_status.running;
   assign rsp_is_stopped      = rsp_status.stopped;
   assign rsp_is_completed    = rsp_status.completed;

endmodule
`default_nettype wire
